// ===== rtl/tcp_frame_filter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// tcp_frame_filter_unit_assert: assertion macros
// Concurrent assertion helpers for the frame filter, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef TCP_FRAME_FILTER_UNIT_ASSERT_SVH
`define TCP_FRAME_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define TFF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tff assertion failed: same-cycle implication");

// next-cycle implication
`define TFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tff assertion failed: next-cycle implication");

`endif

// ===== rtl/tff_pkg.sv =====
// ----------------------------------------------------------------------------
// tff_pkg
// Constants and types of the Ethernet / IPv4 / TCP frame filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tff_pkg;

    localparam int POSITION_LIMIT_DEFAULT = 2047;
    localparam logic [15:0] LISTEN_PORT_RESET = 16'd3000;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;

    localparam int ETH_HDR_BYTES = 14;
    localparam int IP_MIN_BYTES  = 24;
    localparam int IHL_MIN       = 5;

    localparam int OFF_ETYPE_HI = 12;
    localparam int OFF_ETYPE_LO = 13;
    localparam int OFF_IHL      = 14;
    localparam int OFF_TLEN_HI  = 16;
    localparam int OFF_TLEN_LO  = 17;
    localparam int OFF_PROTO    = 23;
    localparam int TCP_PORT_HI  = 2;
    localparam int TCP_PORT_LO  = 3;
    localparam int TCP_DOFF     = 12;

    typedef enum logic [2:0] {
        V_OK       = 3'd0,
        V_NOT_IPV4 = 3'd1,
        V_NOT_TCP  = 3'd2,
        V_PORT     = 3'd3,
        V_TRUNC    = 3'd4,
        V_BADLEN   = 3'd5
    } verdict_t;

endpackage

// ===== rtl/tff_ifs.sv =====
// ----------------------------------------------------------------------------
// tff channel interfaces
// Valid/ready channels for frame bytes, verdicts and the listen-port write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tff_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface tff_result_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  verdict;
    logic [15:0] payload_length;
    logic [7:0]  payload_offset;

    modport source (output valid, accepted, verdict, payload_length, payload_offset,
                    input ready);
    modport sink   (input valid, accepted, verdict, payload_length, payload_offset,
                    output ready);
endinterface

interface tff_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] listen_port;

    modport source (output valid, listen_port, input ready);
    modport sink   (input valid, listen_port, output ready);
endinterface

// ===== rtl/tcp_frame_filter_unit.sv =====
// A verdict is registered from the byte carrying the frame end and is valid in the cycle after it is taken.
// Throughput: one frame byte per cycle unless a held result is not taken; the header state updates in a single pass.
// The result register decouples the output, so bytes keep flowing while it is taken.
// Reset: rst_n clears the parse state, the result valid and sets listen port to 3000.
// ----------------------------------------------------------------------------
// tcp_frame_filter_unit
// Parses Ethernet / IPv4 / TCP headers byte by byte and filters on the port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_frame_filter_unit_assert.svh"

module tcp_frame_filter_unit
    import tff_pkg::*;
#(
    parameter int POSITION_LIMIT = POSITION_LIMIT_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    tff_frame_if.sink    frame,
    tff_result_if.source result,
    tff_cfg_if.sink      cfg
);

    localparam int POS_W = $clog2(POSITION_LIMIT + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(POSITION_LIMIT);

    logic [15:0]      listen_port_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      etype_reg, etype_cap, etype_next;
    logic [3:0]       ihl_reg, ihl_cap, ihl_next;
    logic [15:0]      tlen_reg, tlen_cap, tlen_next;
    logic [7:0]       proto_reg, proto_cap, proto_next;
    logic [15:0]      dport_reg, dport_cap, dport_next;
    logic [3:0]       thw_reg, thw_cap, thw_next;
    logic             hdone_reg, hdone_cap, hdone_next;
    logic [POS_W-1:0] pos_cap;

    logic             res_valid_reg, res_valid_next;
    verdict_t         verdict_reg, verdict_next;
    logic [15:0]      plen_reg, plen_next;
    logic [7:0]       poff_reg, poff_next;

    logic             take;
    logic             tcp_gate;
    logic [6:0]       tcp_start;
    logic [6:0]       hdrs;

    assign frame.ready = !res_valid_reg || result.ready;
    assign cfg.ready   = 1'b1;
    assign take        = frame.valid && frame.ready;

    assign tcp_start = 7'(ETH_HDR_BYTES) + {1'b0, ihl_reg, 2'b00};
    assign tcp_gate  = (pos_reg > POS_W'(OFF_IHL)) && (ihl_reg >= 4'(IHL_MIN));

    // capture header fields at their offsets
    always_comb
    begin
        etype_cap = etype_reg;
        ihl_cap   = ihl_reg;
        tlen_cap  = tlen_reg;
        proto_cap = proto_reg;
        dport_cap = dport_reg;
        thw_cap   = thw_reg;
        hdone_cap = hdone_reg;
        pos_cap   = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;

        if (pos_reg == POS_W'(OFF_ETYPE_HI)) etype_cap[15:8] = frame.frame_byte;
        if (pos_reg == POS_W'(OFF_ETYPE_LO)) etype_cap[7:0]  = frame.frame_byte;
        if (pos_reg == POS_W'(OFF_IHL))      ihl_cap         = frame.frame_byte[3:0];
        if (pos_reg == POS_W'(OFF_TLEN_HI))  tlen_cap[15:8]  = frame.frame_byte;
        if (pos_reg == POS_W'(OFF_TLEN_LO))  tlen_cap[7:0]   = frame.frame_byte;
        if (pos_reg == POS_W'(OFF_PROTO))    proto_cap       = frame.frame_byte;

        if (tcp_gate)
        begin
            if (pos_reg == POS_W'(tcp_start) + POS_W'(TCP_PORT_HI))
                dport_cap[15:8] = frame.frame_byte;
            if (pos_reg == POS_W'(tcp_start) + POS_W'(TCP_PORT_LO))
                dport_cap[7:0] = frame.frame_byte;
            if (pos_reg == POS_W'(tcp_start) + POS_W'(TCP_DOFF))
            begin
                thw_cap   = frame.frame_byte[7:4];
                hdone_cap = 1'b1;
            end
        end
    end

    // decide the verdict from the updated header state
    assign hdrs = {1'b0, ihl_cap, 2'b00} + {1'b0, thw_cap, 2'b00};

    always_comb
    begin
        plen_next = 16'd0;
        poff_next = 8'd0;
        priority if (pos_cap < POS_W'(ETH_HDR_BYTES))
            verdict_next = V_TRUNC;
        else if (etype_cap != ETHERTYPE_IPV4)
            verdict_next = V_NOT_IPV4;
        else if (pos_cap < POS_W'(IP_MIN_BYTES))
            verdict_next = V_TRUNC;
        else if (ihl_cap < 4'(IHL_MIN))
            verdict_next = V_BADLEN;
        else if (proto_cap != PROTO_TCP)
            verdict_next = V_NOT_TCP;
        else if (!hdone_cap)
            verdict_next = V_TRUNC;
        else if (dport_cap != listen_port_reg)
            verdict_next = V_PORT;
        else if (tlen_cap < 16'(hdrs))
            verdict_next = V_BADLEN;
        else
        begin
            verdict_next = V_OK;
            plen_next    = tlen_cap - 16'(hdrs);
            poff_next    = 8'(ETH_HDR_BYTES) + 8'(hdrs);
        end
    end

    // clear per-frame state on the last byte
    always_comb
    begin
        pos_next   = pos_reg;
        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        tlen_next  = tlen_reg;
        proto_next = proto_reg;
        dport_next = dport_reg;
        thw_next   = thw_reg;
        hdone_next = hdone_reg;
        if (take)
        begin
            if (frame.frame_end)
            begin
                pos_next   = '0;
                etype_next = '0;
                ihl_next   = '0;
                tlen_next  = '0;
                proto_next = '0;
                dport_next = '0;
                thw_next   = '0;
                hdone_next = 1'b0;
            end
            else
            begin
                pos_next   = pos_cap;
                etype_next = etype_cap;
                ihl_next   = ihl_cap;
                tlen_next  = tlen_cap;
                proto_next = proto_cap;
                dport_next = dport_cap;
                thw_next   = thw_cap;
                hdone_next = hdone_cap;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take && frame.frame_end)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_port_reg <= LISTEN_PORT_RESET;
            pos_reg         <= '0;
            etype_reg       <= '0;
            ihl_reg         <= '0;
            tlen_reg        <= '0;
            proto_reg       <= '0;
            dport_reg       <= '0;
            thw_reg         <= '0;
            hdone_reg       <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                listen_port_reg <= cfg.listen_port;
            pos_reg       <= pos_next;
            etype_reg     <= etype_next;
            ihl_reg       <= ihl_next;
            tlen_reg      <= tlen_next;
            proto_reg     <= proto_next;
            dport_reg     <= dport_next;
            thw_reg       <= thw_next;
            hdone_reg     <= hdone_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // hold the result payload until a new verdict is loaded
    always_ff @(posedge clk)
    begin
        if (take && frame.frame_end)
        begin
            verdict_reg <= verdict_next;
            plen_reg    <= plen_next;
            poff_reg    <= poff_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.accepted       = (verdict_reg == V_OK);
    assign result.verdict        = verdict_reg;
    assign result.payload_length = plen_reg;
    assign result.payload_offset = poff_reg;

    `TFF_ASSERT_NEXT(a_end_gives_result, clk, rst_n, take && frame.frame_end, res_valid_reg)
    `TFF_ASSERT_NEXT(a_end_clears_state, clk, rst_n, take && frame.frame_end,
                     pos_reg == '0 && !hdone_reg)
    `TFF_ASSERT_IMPLY(a_ok_offset_floor, clk, rst_n, res_valid_reg && verdict_reg == V_OK,
                      poff_reg >= 8'(ETH_HDR_BYTES + 4 * IHL_MIN))

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: frame filter testbench
// Sends Ethernet frames byte by byte into tcp_frame_filter_unit and checks
// each verdict against a pinned result or a header-parsing predictor. A table
// of hand-made frames comes first, covering short headers, wrong EtherType and
// protocol, small IHL, port match and mismatch, and payload length extremes.
// Random frames follow under several listen-port settings.
// Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tff_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int BYTES_PER_PHASE = 80;
    localparam int FRAMES_PER_PHASE = 1;

    typedef struct {
        int unsigned pos;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [15:0] tot_len;
        logic [7:0]  proto;
        logic [15:0] dport;
        logic [3:0]  doff;
        bit          tcp_seen;
    } parse_state_t;

    typedef struct {
        logic        accepted;
        verdict_t    verdict;
        logic [15:0] payload_length;
        logic [7:0]  payload_offset;
    } verdict_rec_t;

    typedef struct {
        bit           pinned;
        verdict_rec_t rec;
    } frame_pin_t;

    typedef struct {
        int          nbytes;
        logic [15:0] etype;
        logic [7:0]  vihl;
        logic [15:0] tlen;
        logic [7:0]  proto;
        logic [15:0] dport;
        logic [7:0]  doffb;
        bit          pinned;
        verdict_t    verdict;
        logic [15:0] plen;
        logic [7:0]  poff;
    } probe_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tff_frame_if  frame_ch ();
    tff_result_if result_ch ();
    tff_cfg_if    cfg_ch ();

    tcp_frame_filter_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    parse_state_t ps;
    logic [15:0]  listen_port_model;
    verdict_rec_t verdicts_due [$];
    frame_pin_t   frame_pins [$];
    logic [7:0]   frame_bytes [$];

    bit quiet;
    int fails;
    int stall_left;
    int idle_cycles;
    int bytes_in;
    int frames_sent;
    int settings_used;
    int verdict_tally [6];

    probe_row_t probe_rows [19] = '{
        '{1,   16'h0800, 8'h45, 16'd40,   8'd6,   16'd3000, 8'h50, 1'b1, V_TRUNC,    16'd0,     8'd0},
        '{13,  16'h0800, 8'h45, 16'd40,   8'd6,   16'd3000, 8'h50, 1'b1, V_TRUNC,    16'd0,     8'd0},
        '{14,  16'h86DD, 8'h45, 16'd40,   8'd6,   16'd3000, 8'h50, 1'b1, V_NOT_IPV4, 16'd0,     8'd0},
        '{14,  16'h0800, 8'h45, 16'd40,   8'd6,   16'd3000, 8'h50, 1'b1, V_TRUNC,    16'd0,     8'd0},
        '{23,  16'h0800, 8'h45, 16'd40,   8'd6,   16'd3000, 8'h50, 1'b1, V_TRUNC,    16'd0,     8'd0},
        '{24,  16'h0800, 8'h44, 16'd40,   8'd6,   16'd3000, 8'h50, 1'b1, V_BADLEN,   16'd0,     8'd0},
        '{60,  16'h0800, 8'h40, 16'd40,   8'd6,   16'd3000, 8'h50, 1'b1, V_BADLEN,   16'd0,     8'd0},
        '{54,  16'h0800, 8'h45, 16'd40,   8'd17,  16'd3000, 8'h50, 1'b1, V_NOT_TCP,  16'd0,     8'd0},
        '{46,  16'h0800, 8'h45, 16'd40,   8'd6,   16'd3000, 8'h50, 1'b1, V_TRUNC,    16'd0,     8'd0},
        '{54,  16'h0800, 8'h45, 16'd40,   8'd6,   16'd3000, 8'h50, 1'b1, V_OK,       16'd0,     8'd54},
        '{54,  16'h0800, 8'h45, 16'd40,   8'd6,   16'd3001, 8'h50, 1'b1, V_PORT,     16'd0,     8'd0},
        '{134, 16'h0800, 8'h4F, 16'hFFFF, 8'd6,   16'd3000, 8'hF0, 1'b1, V_OK,       16'd65415, 8'd134},
        '{134, 16'h0800, 8'h4F, 16'd119,  8'd6,   16'd3000, 8'hF0, 1'b1, V_BADLEN,   16'd0,     8'd0},
        '{47,  16'h0800, 8'h45, 16'd20,   8'd6,   16'd3000, 8'h00, 1'b1, V_OK,       16'd0,     8'd34},
        '{54,  16'h0800, 8'h65, 16'd1500, 8'd6,   16'd3000, 8'h5F, 1'b1, V_OK,       16'd1460,  8'd54},
        '{54,  16'h0800, 8'h45, 16'h0000, 8'd6,   16'd3000, 8'h50, 1'b1, V_BADLEN,   16'd0,     8'd0},
        '{60,  16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF,  16'hFFFF, 8'hFF, 1'b1, V_NOT_IPV4, 16'd0,     8'd0},
        '{64,  16'h0800, 8'h47, 16'd1000, 8'd6,   16'd0,    8'h8A, 1'b0, V_OK,       16'd0,     8'd0},
        '{90,  16'h0800, 8'h49, 16'd300,  8'd6,   16'd3000, 8'hC3, 1'b0, V_OK,       16'd0,     8'd0}
    };

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void clear_parse();
        ps.pos      = 0;
        ps.etype    = '0;
        ps.ihl      = '0;
        ps.tot_len  = '0;
        ps.proto    = '0;
        ps.dport    = '0;
        ps.doff     = '0;
        ps.tcp_seen = 1'b0;
    endfunction

    // Advance the header parser by one byte; return 1 with a verdict on frame end.
    function automatic bit step_parser(input logic [7:0] b, input logic last,
                                       output verdict_rec_t rec);
        int tcp_base;
        int hdr_bytes;
        rec.accepted       = 1'b0;
        rec.verdict        = V_OK;
        rec.payload_length = '0;
        rec.payload_offset = '0;
        if (ps.pos == OFF_ETYPE_HI) ps.etype[15:8]   = b;
        if (ps.pos == OFF_ETYPE_LO) ps.etype[7:0]    = b;
        if (ps.pos == OFF_IHL)      ps.ihl           = b[3:0];
        if (ps.pos == OFF_TLEN_HI)  ps.tot_len[15:8] = b;
        if (ps.pos == OFF_TLEN_LO)  ps.tot_len[7:0]  = b;
        if (ps.pos == OFF_PROTO)    ps.proto         = b;
        if (ps.pos > OFF_IHL && ps.ihl >= IHL_MIN)
        begin
            tcp_base = ETH_HDR_BYTES + 4 * ps.ihl;
            if (ps.pos == tcp_base + TCP_PORT_HI) ps.dport[15:8] = b;
            if (ps.pos == tcp_base + TCP_PORT_LO) ps.dport[7:0]  = b;
            if (ps.pos == tcp_base + TCP_DOFF)
            begin
                ps.doff     = b[7:4];
                ps.tcp_seen = 1'b1;
            end
        end
        if (ps.pos < POSITION_LIMIT_DEFAULT)
            ps.pos++;
        if (!last)
            return 1'b0;

        hdr_bytes = 4 * ps.ihl + 4 * ps.doff;
        if (ps.pos < ETH_HDR_BYTES)
            rec.verdict = V_TRUNC;
        else if (ps.etype != ETHERTYPE_IPV4)
            rec.verdict = V_NOT_IPV4;
        else if (ps.pos < IP_MIN_BYTES)
            rec.verdict = V_TRUNC;
        else if (ps.ihl < IHL_MIN)
            rec.verdict = V_BADLEN;
        else if (ps.proto != PROTO_TCP)
            rec.verdict = V_NOT_TCP;
        else if (!ps.tcp_seen)
            rec.verdict = V_TRUNC;
        else if (ps.dport != listen_port_model)
            rec.verdict = V_PORT;
        else if (ps.tot_len < hdr_bytes)
            rec.verdict = V_BADLEN;
        else
        begin
            rec.verdict        = V_OK;
            rec.accepted       = 1'b1;
            rec.payload_length = 16'(ps.tot_len - hdr_bytes);
            rec.payload_offset = 8'(ETH_HDR_BYTES + hdr_bytes);
        end
        clear_parse();
        return 1'b1;
    endfunction

    function automatic void place(input int pos, input logic [7:0] val);
        if (pos < frame_bytes.size())
            frame_bytes[pos] = val;
    endfunction

    function automatic void build_frame(input int nbytes, input logic [15:0] etype,
                                        input logic [7:0] vihl, input logic [15:0] tlen,
                                        input logic [7:0] proto, input logic [15:0] dport,
                                        input logic [7:0] doffb);
        int base;
        frame_bytes.delete();
        for (int i = 0; i < nbytes; i++)
            frame_bytes.push_back(8'($urandom));
        base = ETH_HDR_BYTES + 4 * vihl[3:0];
        place(OFF_ETYPE_HI, etype[15:8]);
        place(OFF_ETYPE_LO, etype[7:0]);
        place(OFF_IHL, vihl);
        place(OFF_TLEN_HI, tlen[15:8]);
        place(OFF_TLEN_LO, tlen[7:0]);
        place(OFF_PROTO, proto);
        if (vihl[3:0] >= IHL_MIN)
        begin
            place(base + TCP_PORT_HI, dport[15:8]);
            place(base + TCP_PORT_LO, dport[7:0]);
            place(base + TCP_DOFF, doffb);
        end
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            frame_ch.valid <= 1'b0;
        end
        @(negedge clk);
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= b;
        frame_ch.frame_end  <= last;
        do @(posedge clk); while (!frame_ch.ready);
    endtask

    task automatic send_frame(input frame_pin_t pin);
        frame_pins.push_back(pin);
        foreach (frame_bytes[i])
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    task automatic random_frame(input int stretch);
        int          kind;
        int          ihl;
        int          doff;
        int          full;
        int          nbytes;
        logic [15:0] tlen;
        logic [15:0] port;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [3:0]  version;
        frame_pin_t  pin;
        pin.pinned = 1'b0;
        kind = (stretch > 0) ? 0 : $urandom_range(0, 99);
        if (kind < 80)
        begin
            ihl     = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
            doff    = ($urandom_range(0, 99) < 85) ? $urandom_range(5, 15) : $urandom_range(0, 4);
            tlen    = ($urandom_range(0, 99) < 80)
                      ? 16'(4 * ihl + 4 * doff + $urandom_range(0, 1460))
                      : 16'($urandom);
            port    = ($urandom_range(0, 99) < 65) ? listen_port_model : 16'($urandom);
            etype   = ($urandom_range(0, 99) < 90) ? ETHERTYPE_IPV4 : 16'($urandom);
            proto   = ($urandom_range(0, 99) < 90) ? PROTO_TCP : 8'($urandom);
            version = ($urandom_range(0, 99) < 80) ? 4'h4 : 4'($urandom);
            full    = ETH_HDR_BYTES + 4 * ihl + TCP_DOFF + 1;
            if (stretch > 0)
                nbytes = full + stretch;
            else if ($urandom_range(0, 99) < 85)
                nbytes = full + $urandom_range(0, 24);
            else
                nbytes = $urandom_range(1, full);
            build_frame(nbytes, etype, {version, 4'(ihl)}, tlen, proto, port,
                        {4'(doff), 4'($urandom)});
        end
        else
        begin
            etype = ($urandom_range(0, 1) == 0) ? ETHERTYPE_IPV4 : 16'($urandom);
            build_frame($urandom_range(1, 70), etype, 8'($urandom), 16'($urandom),
                        8'($urandom), 16'($urandom), 8'($urandom));
        end
        send_frame(pin);
    endtask

    // Hold the sender until every verdict is back, then let the block settle.
    task automatic drain();
        @(negedge clk);
        frame_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_listen_port(input logic [15:0] port);
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.listen_port <= port;
        do @(posedge clk); while (!cfg_ch.ready);
        listen_port_model = port;
        settings_used++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            stall_left = idle_len();
        end
    end

    always @(posedge clk)
    begin : monitor
        verdict_rec_t rec;
        verdict_rec_t due;
        frame_pin_t   pin;
        if (rst_n)
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                bytes_in++;
                if (step_parser(frame_ch.frame_byte, frame_ch.frame_end, rec))
                begin
                    pin = frame_pins.pop_front();
                    verdicts_due.push_back(pin.pinned ? pin.rec : rec);
                end
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("verdict: result with no frame pending, got %0d", result_ch.verdict);
                    fails++;
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (result_ch.verdict < 6)
                        verdict_tally[result_ch.verdict]++;
                    if (result_ch.accepted !== due.accepted)
                    begin
                        $error("accepted: expected %0b, got %0b", due.accepted, result_ch.accepted);
                        fails++;
                    end
                    if (result_ch.verdict !== due.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d", due.verdict, result_ch.verdict);
                        fails++;
                    end
                    if (result_ch.payload_length !== due.payload_length)
                    begin
                        $error("payload_length: expected %0d, got %0d",
                               due.payload_length, result_ch.payload_length);
                        fails++;
                    end
                    if (result_ch.payload_offset !== due.payload_offset)
                    begin
                        $error("payload_offset: expected %0d, got %0d",
                               due.payload_offset, result_ch.payload_offset);
                        fails++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        frame_pin_t  pin;
        int          phase_bytes;
        int          phase_frames;
        logic [15:0] phase_ports [5];

        frame_ch.valid      = 1'b0;
        frame_ch.frame_byte = '0;
        frame_ch.frame_end  = 1'b0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.listen_port  = '0;
        rst_n               = 1'b0;
        quiet               = 1'b0;
        fails               = 0;
        stall_left          = 0;
        idle_cycles         = 0;
        bytes_in            = 0;
        frames_sent         = 0;
        settings_used       = 1;
        foreach (verdict_tally[i])
            verdict_tally[i] = 0;
        listen_port_model = LISTEN_PORT_RESET;
        clear_parse();
        phase_ports = '{16'hFFFF, 16'h0000, 16'($urandom), 16'd80, LISTEN_PORT_RESET};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (probe_rows[i])
        begin
            build_frame(probe_rows[i].nbytes, probe_rows[i].etype, probe_rows[i].vihl,
                        probe_rows[i].tlen, probe_rows[i].proto, probe_rows[i].dport,
                        probe_rows[i].doffb);
            pin.pinned             = probe_rows[i].pinned;
            pin.rec.accepted       = (probe_rows[i].verdict == V_OK);
            pin.rec.verdict        = probe_rows[i].verdict;
            pin.rec.payload_length = probe_rows[i].plen;
            pin.rec.payload_offset = probe_rows[i].poff;
            send_frame(pin);
        end

        foreach (phase_ports[p])
        begin
            drain();
            set_listen_port(phase_ports[p]);
            quiet        = (p == 3);
            phase_bytes  = 0;
            phase_frames = 0;
            while (phase_bytes < BYTES_PER_PHASE || phase_frames < FRAMES_PER_PHASE)
            begin
                if (p != 3)
                    quiet = ($urandom_range(0, 7) == 0);
                random_frame(0);
                phase_bytes += frame_bytes.size();
                phase_frames++;
            end
        end

        quiet = 1'b0;
        drain();

        $display("run covered %0d frame bytes in %0d frames over %0d listen-port settings",
                 bytes_in, frames_sent, settings_used);
        $display("verdicts seen: ok %0d, not ipv4 %0d, not tcp %0d, port %0d,",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3]);
        $display("  truncated %0d, bad length %0d", verdict_tally[4], verdict_tally[5]);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tff_pkg.sv
rtl/tff_ifs.sv
rtl/tcp_frame_filter_unit.sv
tb/tb_top.sv
